@@ rtl/i2c_eeprom_access_master_unit_defines.svh @@
// Assertion macros used by the checker file.
`ifndef I2C_EEPROM_ACCESS_MASTER_UNIT_DEFINES_SVH
`define I2C_EEPROM_ACCESS_MASTER_UNIT_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define IEAM_ASSERT_IMP(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("lbl");
// Implication checked in the cycle after the condition.
`define IEAM_ASSERT_NEXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("lbl");
`endif

@@ rtl/ieam_pkg.sv @@
// Package with the request types, step codes and byte roles of the EEPROM master.
`timescale 1ns / 1ps
package ieam_pkg;
  localparam logic [9:0]  PhaseTicksReset = 10'd40;
  localparam logic [9:0]  SampleTicksReset = 10'd16;
  localparam logic [19:0] WriteWaitReset = 20'd40000;

  localparam logic [1:0] REG_PHASE  = 2'd0;
  localparam logic [1:0] REG_SAMPLE = 2'd1;
  localparam logic [1:0] REG_WWAIT  = 2'd2;

  localparam logic [1:0] REQ_NONE  = 2'd0;
  localparam logic [1:0] REQ_PROBE = 2'd1;
  localparam logic [1:0] REQ_WRITE = 2'd2;
  localparam logic [1:0] REQ_READ  = 2'd3;

  typedef enum logic [4:0] {
    ST_IDLE, ST_SA, ST_SB, ST_SC, ST_SD, ST_SE,
    ST_WA, ST_WB, ST_WC,
    ST_KA, ST_KB, ST_KC, ST_KD, ST_KE,
    ST_WAITDATA,
    ST_RA, ST_RB, ST_RC,
    ST_AA, ST_AB, ST_AC, ST_AD,
    ST_PA, ST_PB, ST_PC, ST_PD,
    ST_WW
  } step_t;

  typedef enum logic [2:0] {
    ROLE_DEVW, ROLE_HI, ROLE_LO, ROLE_DATA, ROLE_DEVR
  } role_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [6:0]  dev_addr;
    logic [15:0] mem_addr;
    logic [7:0]  byte_count;
    logic [7:0]  wr_data;
    logic        wr_data_valid;
    logic        sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl;
    logic       sda_out;
    logic       sda_oe;
    logic [7:0] rd_data;
    logic       rd_valid;
    logic       rd_last;
    logic       wr_data_request;
    logic       busy_res;
    logic       done_res;
    logic       status;
  } out_item_t;
endpackage

@@ rtl/i2c_eeprom_access_master_unit.sv @@
// Top level of the tick-driven I2C master for EEPROMs with 16-bit addressing.
//
// Usage: every request on the input channel is one timing tick. It carries
// the sampled SDA level and, while the block is idle, a command (probe,
// write or read). Each accepted request yields exactly one result request
// that holds the bus levels (SCL, SDA drive and enable), any byte read,
// the write byte request and the busy, done and status flags.
// The tick is worked on in the cycle it is accepted; its result goes to the
// output register, or to the skid register while the output stalls.
// Throughput is one request per cycle while input ready is high; the
// phase and sample tick registers set how many ticks each bus phase lasts.
// When the receiver stalls, the result waits in the output register and a
// single skid register absorbs one more tick, so input ready only drops
// once both are full; no tick is lost or repeated.
// Reset (synchronous, active high) returns the sequencer to idle, releases
// the timing counter, drives SCL and SDA high and loads the register
// defaults: 40 ticks per phase, 16 sample ticks and a 40000-tick write wait.
// Configuration writes are taken in any cycle outside reset through the write port;
// indexes beyond the register list are ignored.
`timescale 1ns / 1ps
module i2c_eeprom_access_master_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  ieam_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ieam_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [19:0]         cfg_wdata
);
  logic [9:0]  phase_ticks;
  logic [9:0]  sample_ticks;
  logic [19:0] write_wait_ticks;

  ieam_pkg::step_t step, step_next;
  ieam_pkg::role_t role, role_next;
  logic [19:0] tick_count, tick_count_next;
  logic [3:0]  bit_index, bit_index_next;
  logic [7:0]  shift_byte, shift_byte_next;
  logic [7:0]  bytes_left, bytes_left_next;
  logic [15:0] saved_mem_addr, saved_mem_addr_next;
  logic [6:0]  saved_dev_addr, saved_dev_addr_next;
  logic [1:0]  op_kind, op_kind_next;
  logic        nack, nack_next, fail, fail_next;
  logic        lvl_scl, lvl_scl_next, lvl_sda, lvl_sda_next, lvl_oe, lvl_oe_next;
  ieam_pkg::out_item_t res;

  // Output register plus skid register.
  logic                out_full, skid_full;
  ieam_pkg::out_item_t skid_data;
  logic                accept;

  assign in_ready  = !skid_full;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_ticks      <= ieam_pkg::PhaseTicksReset;
      sample_ticks     <= ieam_pkg::SampleTicksReset;
      write_wait_ticks <= ieam_pkg::WriteWaitReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ieam_pkg::REG_PHASE:  phase_ticks      <= cfg_wdata[9:0];
        ieam_pkg::REG_SAMPLE: sample_ticks     <= cfg_wdata[9:0];
        ieam_pkg::REG_WWAIT:  write_wait_ticks <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Sequencer: on each accepted tick the phase count runs down, and once it is out
  // a step is taken; a step may fall through into the next one within the same
  // tick, as the bus protocol chains them. The chains are short and bounded, so they are unrolled as six passes.
  always_comb begin
    logic [19:0] ph, sm;
    logic        go;
    ph = (phase_ticks == 10'd0) ? 20'd0 : {10'd0, phase_ticks - 10'd1};
    sm = (sample_ticks == 10'd0) ? 20'd0 : {10'd0, sample_ticks - 10'd1};
    step_next = step; role_next = role; tick_count_next = tick_count;
    bit_index_next = bit_index; shift_byte_next = shift_byte;
    bytes_left_next = bytes_left; saved_mem_addr_next = saved_mem_addr;
    saved_dev_addr_next = saved_dev_addr; op_kind_next = op_kind;
    nack_next = nack; fail_next = fail;
    lvl_scl_next = lvl_scl; lvl_sda_next = lvl_sda; lvl_oe_next = lvl_oe;
    res = '0;
    go = 1'b0;
    if (tick_count != 20'd0) begin
      tick_count_next = tick_count - 20'd1;
    end else begin
      go = 1'b1;
    end
    for (int pass = 0; pass < 6; pass++) begin
      if (go) begin
        go = 1'b0;
        unique case (step_next)
          ieam_pkg::ST_IDLE: begin
            if (in_data.req_type != ieam_pkg::REQ_NONE) begin
              op_kind_next = in_data.req_type;
              saved_dev_addr_next = in_data.dev_addr;
              saved_mem_addr_next = in_data.mem_addr;
              bytes_left_next = (in_data.byte_count == 8'd0) ? 8'd1 : in_data.byte_count;
              fail_next = 1'b0; nack_next = 1'b0;
              role_next = ieam_pkg::ROLE_DEVW;
              step_next = ieam_pkg::ST_SA;
              go = 1'b1;
            end
          end
          ieam_pkg::ST_SA: begin
            lvl_oe_next = 1'b1; lvl_sda_next = 1'b1;
            tick_count_next = ph; step_next = ieam_pkg::ST_SB;
          end
          ieam_pkg::ST_SB: begin
            lvl_scl_next = 1'b1; tick_count_next = ph; step_next = ieam_pkg::ST_SC;
          end
          ieam_pkg::ST_SC: begin
            lvl_sda_next = 1'b0; tick_count_next = ph; step_next = ieam_pkg::ST_SD;
          end
          ieam_pkg::ST_SD: begin
            lvl_scl_next = 1'b0; tick_count_next = ph; step_next = ieam_pkg::ST_SE;
          end
          ieam_pkg::ST_SE: begin
            shift_byte_next = {saved_dev_addr_next, role_next == ieam_pkg::ROLE_DEVR};
            bit_index_next = 4'd0; step_next = ieam_pkg::ST_WA; go = 1'b1;
          end
          ieam_pkg::ST_WA: begin
            lvl_oe_next = 1'b1; lvl_sda_next = shift_byte_next[7];
            tick_count_next = ph; step_next = ieam_pkg::ST_WB;
          end
          ieam_pkg::ST_WB: begin
            lvl_scl_next = 1'b1; tick_count_next = ph; step_next = ieam_pkg::ST_WC;
          end
          ieam_pkg::ST_WC: begin
            lvl_scl_next = 1'b0; tick_count_next = ph;
            shift_byte_next = {shift_byte_next[6:0], 1'b0};
            bit_index_next = bit_index_next + 4'd1;
            step_next = (bit_index_next >= 4'd8) ? ieam_pkg::ST_KA : ieam_pkg::ST_WA;
          end
          ieam_pkg::ST_KA: begin
            lvl_oe_next = 1'b0; lvl_sda_next = 1'b0;
            tick_count_next = ph; step_next = ieam_pkg::ST_KB;
          end
          ieam_pkg::ST_KB: begin
            lvl_scl_next = 1'b1; tick_count_next = sm; step_next = ieam_pkg::ST_KC;
          end
          ieam_pkg::ST_KC: begin
            nack_next = in_data.sda_in; tick_count_next = sm; step_next = ieam_pkg::ST_KD;
          end
          ieam_pkg::ST_KD: begin
            lvl_scl_next = 1'b0; tick_count_next = ph; step_next = ieam_pkg::ST_KE;
          end
          ieam_pkg::ST_KE: begin
            go = 1'b1;
            if (nack_next) begin
              fail_next = 1'b1; step_next = ieam_pkg::ST_PA;
            end else if (role_next == ieam_pkg::ROLE_DEVW) begin
              if (op_kind_next == ieam_pkg::REQ_PROBE) begin
                step_next = ieam_pkg::ST_PA;
              end else begin
                role_next = ieam_pkg::ROLE_HI;
                shift_byte_next = saved_mem_addr_next[15:8];
                bit_index_next = 4'd0; step_next = ieam_pkg::ST_WA;
              end
            end else if (role_next == ieam_pkg::ROLE_HI) begin
              role_next = ieam_pkg::ROLE_LO;
              shift_byte_next = saved_mem_addr_next[7:0];
              bit_index_next = 4'd0; step_next = ieam_pkg::ST_WA;
            end else if (role_next == ieam_pkg::ROLE_LO) begin
              if (op_kind_next == ieam_pkg::REQ_WRITE) begin
                role_next = ieam_pkg::ROLE_DATA; step_next = ieam_pkg::ST_WAITDATA;
                go = 1'b0;
              end else begin
                role_next = ieam_pkg::ROLE_DEVR; step_next = ieam_pkg::ST_SA;
              end
            end else if (role_next == ieam_pkg::ROLE_DATA) begin
              bytes_left_next = bytes_left_next - 8'd1;
              if (bytes_left_next == 8'd0) begin
                step_next = ieam_pkg::ST_PA;
              end else begin
                step_next = ieam_pkg::ST_WAITDATA; go = 1'b0;
              end
            end else begin
              bit_index_next = 4'd0; shift_byte_next = 8'd0; step_next = ieam_pkg::ST_RA;
            end
          end
          ieam_pkg::ST_WAITDATA: begin
            if (in_data.wr_data_valid) begin
              shift_byte_next = in_data.wr_data; bit_index_next = 4'd0;
              step_next = ieam_pkg::ST_WA; go = 1'b1;
            end
          end
          ieam_pkg::ST_RA: begin
            lvl_oe_next = 1'b0; lvl_sda_next = 1'b0; lvl_scl_next = 1'b1;
            tick_count_next = sm; step_next = ieam_pkg::ST_RB;
          end
          ieam_pkg::ST_RB: begin
            shift_byte_next = {shift_byte_next[6:0], in_data.sda_in};
            tick_count_next = sm; step_next = ieam_pkg::ST_RC;
          end
          ieam_pkg::ST_RC: begin
            lvl_scl_next = 1'b0; tick_count_next = ph;
            bit_index_next = bit_index_next + 4'd1;
            step_next = (bit_index_next >= 4'd8) ? ieam_pkg::ST_AA : ieam_pkg::ST_RA;
          end
          ieam_pkg::ST_AA: begin
            lvl_oe_next = 1'b1; lvl_sda_next = (bytes_left_next <= 8'd1);
            res.rd_valid = 1'b1; res.rd_data = shift_byte_next;
            res.rd_last = (bytes_left_next <= 8'd1);
            tick_count_next = ph; step_next = ieam_pkg::ST_AB;
          end
          ieam_pkg::ST_AB: begin
            lvl_scl_next = 1'b1; tick_count_next = ph; step_next = ieam_pkg::ST_AC;
          end
          ieam_pkg::ST_AC: begin
            lvl_scl_next = 1'b0; tick_count_next = ph; step_next = ieam_pkg::ST_AD;
          end
          ieam_pkg::ST_AD: begin
            bytes_left_next = bytes_left_next - 8'd1;
            go = 1'b1;
            if (bytes_left_next == 8'd0) begin
              step_next = ieam_pkg::ST_PA;
            end else begin
              bit_index_next = 4'd0; shift_byte_next = 8'd0; step_next = ieam_pkg::ST_RA;
            end
          end
          ieam_pkg::ST_PA: begin
            lvl_oe_next = 1'b1; lvl_sda_next = 1'b0;
            tick_count_next = ph; step_next = ieam_pkg::ST_PB;
          end
          ieam_pkg::ST_PB: begin
            lvl_scl_next = 1'b1; tick_count_next = ph; step_next = ieam_pkg::ST_PC;
          end
          ieam_pkg::ST_PC: begin
            lvl_sda_next = 1'b1; tick_count_next = ph; step_next = ieam_pkg::ST_PD;
          end
          ieam_pkg::ST_PD: begin
            if (!fail_next && op_kind_next == ieam_pkg::REQ_WRITE &&
                write_wait_ticks != 20'd0) begin
              tick_count_next = write_wait_ticks - 20'd1;
              step_next = ieam_pkg::ST_WW;
            end else begin
              step_next = ieam_pkg::ST_IDLE;
              res.done_res = 1'b1; res.status = fail_next;
            end
          end
          ieam_pkg::ST_WW: begin
            step_next = ieam_pkg::ST_IDLE;
            res.done_res = 1'b1; res.status = fail_next;
          end
          default: step_next = ieam_pkg::ST_IDLE;
        endcase
      end
    end
    res.scl = lvl_scl_next;
    res.sda_out = lvl_oe_next & lvl_sda_next;
    res.sda_oe = lvl_oe_next;
    res.wr_data_request = (step_next == ieam_pkg::ST_WAITDATA);
    res.busy_res = (step_next != ieam_pkg::ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ieam_pkg::ST_IDLE; role <= ieam_pkg::ROLE_DEVW;
      tick_count <= '0; bit_index <= '0; shift_byte <= '0; bytes_left <= '0;
      saved_mem_addr <= '0; saved_dev_addr <= '0; op_kind <= '0;
      nack <= 1'b0; fail <= 1'b0;
      lvl_scl <= 1'b1; lvl_sda <= 1'b1; lvl_oe <= 1'b1;
    end else if (accept) begin
      step <= step_next; role <= role_next;
      tick_count <= tick_count_next; bit_index <= bit_index_next;
      shift_byte <= shift_byte_next; bytes_left <= bytes_left_next;
      saved_mem_addr <= saved_mem_addr_next; saved_dev_addr <= saved_dev_addr_next;
      op_kind <= op_kind_next; nack <= nack_next; fail <= fail_next;
      lvl_scl <= lvl_scl_next; lvl_sda <= lvl_sda_next; lvl_oe <= lvl_oe_next;
    end
  end

  // The output register takes a new result when empty or draining; a result
  // that arrives while it is stalled goes to the skid register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0; skid_full <= 1'b0;
    end else begin
      if (!out_full || out_ready) begin
        if (skid_full) begin
          out_full <= 1'b1; skid_full <= accept;
        end else begin
          out_full <= accept;
        end
      end else if (accept) begin
        skid_full <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_full || out_ready) begin
      if (skid_full) begin
        out_data <= skid_data;
        if (accept) skid_data <= res;
      end else if (accept) begin
        out_data <= res;
      end
    end else if (accept) begin
      skid_data <= res;
    end
  end
endmodule

@@ rtl/ieam_checker.sv @@
// Port checker for the EEPROM master, bound to the top level.
`timescale 1ns / 1ps
`include "i2c_eeprom_access_master_unit_defines.svh"
module ieam_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input ieam_pkg::out_item_t out_data
);
  `IEAM_ASSERT_IMP(a_done_idle, clk, rst, out_valid && out_data.done_res, !out_data.busy_res)
  `IEAM_ASSERT_IMP(a_status_done, clk, rst, out_valid && out_data.status, out_data.done_res)
  `IEAM_ASSERT_IMP(a_release_low, clk, rst, out_valid && !out_data.sda_oe, !out_data.sda_out)
  `IEAM_ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data))
  // Input back-pressure only appears while a result is waiting at the output.
  `IEAM_ASSERT_IMP(a_stall_full, clk, rst, in_valid && !in_ready, out_valid)
endmodule

bind i2c_eeprom_access_master_unit ieam_checker u_ieam_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
